/* hw/rtl/telnet_command_stripper_unit_defines.svh */
// Assertion macros for the telnet command stripper unit.
`ifndef TELNET_COMMAND_STRIPPER_UNIT_DEFINES_SVH
`define TELNET_COMMAND_STRIPPER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define TCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/tcs_pkg.sv */
// Shared types, telnet codes and reply tables for the telnet command stripper.
package tcs_pkg;

	localparam logic [7:0] CMD_IAC  = 8'd255;
	localparam logic [7:0] CMD_DONT = 8'd254;
	localparam logic [7:0] CMD_DO   = 8'd253;
	localparam logic [7:0] CMD_WONT = 8'd252;
	localparam logic [7:0] CMD_WILL = 8'd251;
	localparam logic [7:0] CMD_SB   = 8'd250;
	localparam logic [7:0] CMD_AYT  = 8'd246;

	localparam int AYT_LEN = 9;
	localparam int IDX_W   = $clog2(AYT_LEN);

	localparam logic [7:0] AYT_REPLY [AYT_LEN] = '{
		8'h0D, 8'h0A, 8'h5B, 8'h59, 8'h45, 8'h53, 8'h5D, 8'h0D, 8'h0A
	};

	typedef enum logic [1:0] {
		K_DATA,
		K_WONT,
		K_DONT,
		K_AYT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	function automatic logic [IDX_W-1:0] last_idx(input cmd_kind_t kind);
		logic [IDX_W-1:0] r;
		unique case (kind)
			K_DATA:         r = IDX_W'(0);
			K_WONT, K_DONT: r = IDX_W'(2);
			K_AYT:          r = IDX_W'(AYT_LEN - 1);
			default:        r = IDX_W'(0);
		endcase
		return r;
	endfunction

	function automatic logic [7:0] reply_byte(input cmd_t cmd, input logic [IDX_W-1:0] idx);
		logic [7:0] r;
		unique case (cmd.kind)
			K_DATA: r = cmd.value;
			K_WONT, K_DONT: begin
				if (idx == IDX_W'(0)) begin
					r = CMD_IAC;
				end else if (idx == IDX_W'(1)) begin
					r = (cmd.kind == K_WONT) ? CMD_WONT : CMD_DONT;
				end else begin
					r = cmd.value;
				end
			end
			K_AYT:   r = AYT_REPLY[idx];
			default: r = cmd.value;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/tcs_front.sv */
// Front end: telnet parse state machine that classifies each received byte.
module tcs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	output tcs_pkg::cmd_req_t cmd_req
);

	typedef enum logic [7:0] {
		ST_DATA  = 8'b0000_0001,
		ST_IAC   = 8'b0000_0010,
		ST_SB    = 8'b0000_0100,
		ST_SBIAC = 8'b0000_1000,
		ST_DO    = 8'b0001_0000,
		ST_DONT  = 8'b0010_0000,
		ST_WILL  = 8'b0100_0000,
		ST_WONT  = 8'b1000_0000
	} parse_state_t;

	parse_state_t state_q;
	parse_state_t state_d;

	always_comb begin
		state_d           = state_q;
		cmd_req.valid     = 1'b0;
		cmd_req.cmd.kind  = tcs_pkg::K_DATA;
		cmd_req.cmd.value = rx_byte;
		unique case (state_q)
			ST_DATA: begin
				if (rx_byte == tcs_pkg::CMD_IAC) begin
					state_d = ST_IAC;
				end else begin
					cmd_req.valid = 1'b1;
				end
			end
			ST_IAC: begin
				state_d = ST_DATA;
				priority if (rx_byte == tcs_pkg::CMD_DO) begin
					state_d = ST_DO;
				end else if (rx_byte == tcs_pkg::CMD_DONT) begin
					state_d = ST_DONT;
				end else if (rx_byte == tcs_pkg::CMD_WILL) begin
					state_d = ST_WILL;
				end else if (rx_byte == tcs_pkg::CMD_WONT) begin
					state_d = ST_WONT;
				end else if (rx_byte == tcs_pkg::CMD_SB) begin
					state_d = ST_SB;
				end else if (rx_byte == tcs_pkg::CMD_AYT) begin
					cmd_req.valid    = 1'b1;
					cmd_req.cmd.kind = tcs_pkg::K_AYT;
				end else if (rx_byte == tcs_pkg::CMD_IAC) begin
					// escaped 255 is data
					cmd_req.valid = 1'b1;
				end else begin
					state_d = ST_DATA;
				end
			end
			ST_SB: begin
				if (rx_byte == tcs_pkg::CMD_IAC) begin
					state_d = ST_SBIAC;
				end
			end
			ST_SBIAC: begin
				state_d = (rx_byte == tcs_pkg::CMD_IAC) ? ST_SB : ST_DATA;
			end
			ST_DO, ST_DONT: begin
				cmd_req.valid    = 1'b1;
				cmd_req.cmd.kind = tcs_pkg::K_WONT;
				state_d          = ST_DATA;
			end
			ST_WILL, ST_WONT: begin
				cmd_req.valid    = 1'b1;
				cmd_req.cmd.kind = tcs_pkg::K_DONT;
				state_d          = ST_DATA;
			end
			default: begin
				state_d = ST_DATA;
			end
		endcase
		if (!accept) begin
			cmd_req.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
		end else if (accept) begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/tcs_cmd_queue.sv */
// Short command queue between the parser and the reply sequencer.
module tcs_cmd_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcs_pkg::cmd_req_t wr_req,
	output logic              full,
	input  logic              rd_pop,
	output tcs_pkg::cmd_req_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tcs_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_rd;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != CNT_W'(0));
	assign head.cmd   = mem_q[rd_ptr_q];
	assign do_rd      = rd_pop && head.valid;

	always_ff @(posedge clk) begin
		if (wr_req.valid) begin
			mem_q[wr_ptr_q] <= wr_req.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_req.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_req.valid && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!wr_req.valid && do_rd) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/tcs_back.sv */
// Back end: expands queued commands into result bytes through an output register.
module tcs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tcs_pkg::cmd_req_t head,
	output logic              head_pop,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        out_byte,
	output logic              to_network,
	output logic              last_of_run
);

	logic [tcs_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic                      load;
	logic                      at_last;

	assign load     = head.valid && (!out_valid_q || pop);
	assign at_last  = (idx_q == tcs_pkg::last_idx(head.cmd.kind));
	assign head_pop = load && at_last;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_last ? '0 : idx_q + tcs_pkg::IDX_W'(1);
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte    <= tcs_pkg::reply_byte(head.cmd, idx_q);
			to_network  <= (head.cmd.kind != tcs_pkg::K_DATA);
			last_of_run <= at_last;
		end
	end

endmodule

/* hw/rtl/telnet_command_stripper_unit.sv */
// Top level of the telnet command stripper: parser, command queue, reply sequencer.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------
//   input    | push / full      | rx_byte
//   result   | empty / pop      | out_byte, to_network, last_of_run
//
// One received byte is taken per cycle while the command queue has room.
// The sequencer expands each command into result bytes: data gives one, a
// refusal three and an AYT reply nine; the sequencer output sets the rate.
// A taken byte's result is registered in the queue, then in the output register.
// Reset clears the parse state, queue pointers and output valid.
// A stalled result side fills the queue; full then stalls the input.
`include "telnet_command_stripper_unit_defines.svh"

module telnet_command_stripper_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       to_network,
	output logic       last_of_run
);

	tcs_pkg::cmd_req_t wr_req;
	tcs_pkg::cmd_req_t head;
	logic              head_pop;
	logic              accept;

	assign accept = push && !full;

	tcs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.cmd_req (wr_req)
	);

	tcs_cmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_req (wr_req),
		.full   (full),
		.rd_pop (head_pop),
		.head   (head)
	);

	tcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_pop    (head_pop),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.to_network  (to_network),
		.last_of_run (last_of_run)
	);

	`TCS_ASSERT_NOW(a_data_is_last, clk, arst_n, !empty && !to_network, last_of_run, "data result not last")
	`TCS_ASSERT_NOW(a_run_is_reply, clk, arst_n, !empty && !last_of_run, to_network, "multi-byte run not a reply")
	`TCS_ASSERT_NEXT(a_run_continues, clk, arst_n, !empty && pop && !last_of_run, !empty, "reply run broken")

endmodule

/* test/telnet_command_stripper_unit_checker.sv */
// Result checker for the telnet command stripper: tracks the parse, predicts and compares bytes.
module telnet_command_stripper_unit_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] rx_byte,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic       to_network,
	input  logic       last_of_run,
	output int         fail_count,
	output int         pending,
	output int         data_seen,
	output int         reply_seen,
	output int         full_stalls
);

	localparam logic TO_APP = 1'b0;
	localparam logic TO_NET = 1'b1;

	typedef enum logic [2:0] {
		PS_DATA,
		PS_IAC,
		PS_SB,
		PS_SB_IAC,
		PS_DO,
		PS_DONT,
		PS_WILL,
		PS_WONT
	} parse_state_t;

	typedef struct packed {
		logic [7:0] value;
		logic       net;
		logic       last;
	} out_beat_t;

	parse_state_t parse_st;
	out_beat_t    expected_q[$];
	out_beat_t    head;

	task automatic queue_beat(input logic [7:0] v, input logic net, input logic last);
		expected_q.push_back(out_beat_t'{v, net, last});
	endtask

	task automatic queue_refusal(input logic [7:0] verb, input logic [7:0] opt);
		queue_beat(tcs_pkg::CMD_IAC, TO_NET, 1'b0);
		queue_beat(verb, TO_NET, 1'b0);
		queue_beat(opt, TO_NET, 1'b1);
	endtask

	task automatic predict_rx(input logic [7:0] c);
		int i;
		case (parse_st)
			PS_DATA: begin
				if (c == tcs_pkg::CMD_IAC) begin
					parse_st = PS_IAC;
				end else begin
					queue_beat(c, TO_APP, 1'b1);
				end
			end
			PS_IAC: begin
				parse_st = PS_DATA;
				case (c)
					tcs_pkg::CMD_DO:   parse_st = PS_DO;
					tcs_pkg::CMD_DONT: parse_st = PS_DONT;
					tcs_pkg::CMD_WILL: parse_st = PS_WILL;
					tcs_pkg::CMD_WONT: parse_st = PS_WONT;
					tcs_pkg::CMD_SB:   parse_st = PS_SB;
					tcs_pkg::CMD_AYT: begin
						for (i = 0; i < tcs_pkg::AYT_LEN; i++) begin
							queue_beat(tcs_pkg::AYT_REPLY[i], TO_NET,
								i == tcs_pkg::AYT_LEN - 1);
						end
					end
					tcs_pkg::CMD_IAC:  queue_beat(tcs_pkg::CMD_IAC, TO_APP, 1'b1);
					default: ;
				endcase
			end
			PS_SB: begin
				if (c == tcs_pkg::CMD_IAC) begin
					parse_st = PS_SB_IAC;
				end
			end
			PS_SB_IAC: parse_st = (c == tcs_pkg::CMD_IAC) ? PS_SB : PS_DATA;
			PS_DO, PS_DONT: begin
				queue_refusal(tcs_pkg::CMD_WONT, c);
				parse_st = PS_DATA;
			end
			default: begin
				queue_refusal(tcs_pkg::CMD_DONT, c);
				parse_st = PS_DATA;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_st = PS_DATA;
			expected_q.delete();
		end else begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual byte %02h net %0b last %0b",
						$time, out_byte, to_network, last_of_run);
					fail_count++;
				end else begin
					head = expected_q.pop_front();
					if (out_byte !== head.value) begin
						$display("%0t: out_byte expected %02h actual %02h",
							$time, head.value, out_byte);
						fail_count++;
					end
					if (to_network !== head.net) begin
						$display("%0t: to_network expected %0b actual %0b",
							$time, head.net, to_network);
						fail_count++;
					end
					if (last_of_run !== head.last) begin
						$display("%0t: last_of_run expected %0b actual %0b",
							$time, head.last, last_of_run);
						fail_count++;
					end
					if (head.net == TO_NET) begin
						reply_seen++;
					end else begin
						data_seen++;
					end
				end
			end
			if (push && !full) begin
				predict_rx(rx_byte);
			end
			if (push && full) begin
				full_stalls++;
			end
		end
		pending = expected_q.size();
	end

endmodule

/* test/telnet_command_stripper_unit_tb.sv */
// Testbench top for the telnet command stripper: clock, reset, byte stimulus, pop pattern, verdict.
module telnet_command_stripper_unit_tb;

	typedef enum int {
		POP_STREAM,
		POP_MOSTLY,
		POP_SPARSE,
		POP_TOGGLE
	} pop_mode_t;

	localparam logic [7:0] CMD_NOP = 8'd241;
	localparam logic [7:0] CMD_SE  = 8'd240;

	localparam logic [7:0] DIRECTED_RX [27] = '{
		8'h00, 8'hFE,
		tcs_pkg::CMD_IAC, tcs_pkg::CMD_IAC,
		tcs_pkg::CMD_IAC, tcs_pkg::CMD_DO, 8'h00,
		tcs_pkg::CMD_IAC, tcs_pkg::CMD_DONT, 8'hFF,
		tcs_pkg::CMD_IAC, tcs_pkg::CMD_WILL, 8'h01,
		tcs_pkg::CMD_IAC, tcs_pkg::CMD_WONT, 8'hAA,
		tcs_pkg::CMD_IAC, tcs_pkg::CMD_AYT,
		tcs_pkg::CMD_IAC, CMD_NOP,
		tcs_pkg::CMD_IAC, tcs_pkg::CMD_SB, 8'h18,
		tcs_pkg::CMD_IAC, tcs_pkg::CMD_IAC, tcs_pkg::CMD_IAC, CMD_SE
	};

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] rx_byte;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       to_network;
	logic       last_of_run;

	int fail_count;
	int pending;
	int data_seen;
	int reply_seen;
	int full_stalls;
	int items_sent;
	int burst_left;
	int nogap_left;
	bit pressure_req;

	telnet_command_stripper_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.to_network (to_network),
		.last_of_run(last_of_run)
	);

	telnet_command_stripper_unit_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.to_network (to_network),
		.last_of_run(last_of_run),
		.fail_count (fail_count),
		.pending    (pending),
		.data_seen  (data_seen),
		.reply_seen (reply_seen),
		.full_stalls(full_stalls)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("** telnet_command_stripper_unit: FAILED **");
		$finish;
	end

	task automatic idle_gap(input int n);
		repeat (n) begin
			@(negedge clk);
			push    <= 1'b0;
			rx_byte <= 8'($urandom);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit counted);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (nogap_left == 0) begin
				idle_gap($urandom_range(0, 6));
			end
		end
		burst_left--;
		if (nogap_left > 0) begin
			nogap_left--;
		end
		@(negedge clk);
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		if (counted) begin
			items_sent++;
		end
	endtask

	task automatic send_sb_block();
		int n;
		int k;
		logic [7:0] b;
		send_byte(tcs_pkg::CMD_IAC, 1'b1);
		send_byte(tcs_pkg::CMD_SB, 1'b1);
		n = $urandom_range(0, 5);
		for (k = 0; k < n; k++) begin
			b = 8'($urandom);
			if (b == tcs_pkg::CMD_IAC) begin
				send_byte(tcs_pkg::CMD_IAC, 1'b1);
			end
			send_byte(b, 1'b1);
		end
		send_byte(tcs_pkg::CMD_IAC, 1'b1);
		send_byte($urandom_range(0, 1) ? CMD_SE : 8'($urandom_range(0, 254)), 1'b1);
	endtask

	// receiver: random pop modes, one long hold-off on request
	initial begin
		pop_mode_t mode;
		int mode_left;
		int hold_left;
		bit held;
		mode      = POP_STREAM;
		mode_left = 0;
		hold_left = 0;
		held      = 1'b0;
		pop       = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_req && !held) begin
				held      = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = pop_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (mode)
					POP_STREAM: pop <= 1'b1;
					POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
					POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
					default:    pop <= mode_left[0];
				endcase
			end
		end
	end

	initial begin
		int i;
		logic [7:0] verb;
		push         = 1'b0;
		rx_byte      = 8'h00;
		arst_n       = 1'b0;
		burst_left   = 0;
		nogap_left   = 0;
		pressure_req = 1'b0;
		items_sent   = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < 27; i++) begin
			send_byte(DIRECTED_RX[i], 1'b1);
		end

		while (items_sent < 300) begin
			if (!pressure_req && items_sent >= 120) begin
				// sender keeps streaming while the receiver holds off
				pressure_req = 1'b1;
				nogap_left   = 40;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_byte(8'($urandom_range(0, 254)), 1'b1);
				4: begin
					send_byte(tcs_pkg::CMD_IAC, 1'b1);
					send_byte(tcs_pkg::CMD_IAC, 1'b1);
				end
				5: begin
					case ($urandom_range(0, 3))
						0:       verb = tcs_pkg::CMD_DO;
						1:       verb = tcs_pkg::CMD_DONT;
						2:       verb = tcs_pkg::CMD_WILL;
						default: verb = tcs_pkg::CMD_WONT;
					endcase
					send_byte(tcs_pkg::CMD_IAC, 1'b1);
					send_byte(verb, 1'b1);
					send_byte(8'($urandom), 1'b1);
				end
				6: begin
					send_byte(tcs_pkg::CMD_IAC, 1'b1);
					send_byte(tcs_pkg::CMD_AYT, 1'b1);
				end
				7: send_sb_block();
				8: begin
					send_byte(tcs_pkg::CMD_IAC, 1'b1);
					send_byte(8'($urandom), 1'b1);
				end
				default: send_byte(8'($urandom), 1'b1);
			endcase
		end

		@(negedge clk);
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("Run covered %0d received bytes: data, IAC IAC, refusals, AYT, subnegotiation, noise.",
			items_sent);
		$display("Checked %0d data and %0d reply bytes; input held off by full for %0d cycles.",
			data_seen, reply_seen, full_stalls);
		if (fail_count == 0) begin
			$display("** telnet_command_stripper_unit: PASSED **");
		end else begin
			$display("** telnet_command_stripper_unit: FAILED **");
		end
		$finish;
	end

endmodule
